// ===== hw/rtl/ekvt_pkg.sv =====
package ekvt_pkg;

  // Operation codes on the func field
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;

  // Status codes on the result word
  localparam logic [2:0] STAT_NEW      = 3'd0;
  localparam logic [2:0] STAT_REPLACED = 3'd1;
  localparam logic [2:0] STAT_HIT      = 3'd2;
  localparam logic [2:0] STAT_MISS     = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;
  localparam logic [2:0] STAT_FLUSHED  = 3'd5;

  // Classified operation handed from the front to the back
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_LOOKUP,
    OP_FLUSH,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        key;
    logic [31:0]        value;
    logic signed [31:0] age;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [4:0]  removed_count;
  } out_word_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] age;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    logic ready;
    logic clearing;
  } back_stat_t;

endpackage

// ===== hw/rtl/ekvt_ram.sv =====
module ekvt_ram #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one port, read the other with a registered output
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ekvt_front.sv =====
module ekvt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ekvt_pkg::in_word_t  item_i,
  output logic                full_o,
  output ekvt_pkg::cmd_req_t  req_o,
  input  ekvt_pkg::back_stat_t stat_i
);
  import ekvt_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push_ok, pop_ok;
  cmd_t       cmd_in;

  // Classify the incoming word
  always_comb begin
    cmd_in.key   = item_i.key;
    cmd_in.value = item_i.value;
    cmd_in.age   = item_i.age;
    case (item_i.func)
      FUNC_INSERT: cmd_in.op = OP_INSERT;
      FUNC_LOOKUP: cmd_in.op = OP_LOOKUP;
      FUNC_FLUSH:  cmd_in.op = OP_FLUSH;
      default:     cmd_in.op = OP_NONE;
    endcase
  end

  // Hold off words while the queue is full or the table is being cleared
  assign full_o  = (count_q == 2'd2) || stat_i.clearing;
  assign push_ok = push_i && !full_o;
  assign pop_ok  = req_o.valid && stat_i.ready;

  assign req_o.valid = (count_q != 2'd0);
  assign req_o.cmd   = slot_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_ok;
    rd_ptr_d = rd_ptr_q ^ pop_ok;
    count_d  = count_q;
    if (push_ok && !pop_ok) begin
      count_d = count_q + 2'd1;
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified command
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("command queue overfilled");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) && !pop_ok |=> count_q == 2'd2)
    else $error("command queue level changed while full and stalled");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.clearing |-> !push_ok && !pop_ok)
    else $error("word moved during table clear");

endmodule

// ===== hw/rtl/ekvt_back.sv =====
module ekvt_back #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32,
  parameter int STAMP_BITS  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ekvt_pkg::cmd_req_t   req_i,
  output ekvt_pkg::back_stat_t stat_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output ekvt_pkg::out_word_t  result_o
);
  import ekvt_pkg::*;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENTRY_W = 1 + KEY_BITS + VALUE_BITS + STAMP_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_CNT = (IDX_W + 1)'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_e;

  state_e                  state_q, state_d;
  logic [IDX_W:0]          cnt_q, cnt_d;
  logic                    pend_q, pend_d;
  logic [IDX_W-1:0]        pend_idx_q, pend_idx_d;
  op_e                     op_q, op_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [VALUE_BITS-1:0]   value_q, value_d;
  logic [STAMP_BITS-1:0]   stamp_q, stamp_d;
  logic                    hit_found_q, hit_found_d;
  logic [IDX_W-1:0]        hit_idx_q, hit_idx_d;
  logic                    free_found_q, free_found_d;
  logic [IDX_W-1:0]        free_idx_q, free_idx_d;
  logic [VALUE_BITS-1:0]   rd_val_q, rd_val_d;
  logic [4:0]              removed_q, removed_d;
  out_word_t               result_q, result_d;
  logic                    res_valid_q, res_valid_d;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic                    ram_re;
  logic [ENTRY_W-1:0]      ram_rdata;

  logic                    e_valid;
  logic [KEY_BITS-1:0]     e_key;
  logic [VALUE_BITS-1:0]   e_value;
  logic [STAMP_BITS-1:0]   e_stamp;
  logic [63:0]             key_ext;
  logic [63:0]             age_ext;
  logic [63:0]             rv_ext;

  ekvt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Split the entry read back from the table
  assign e_valid = ram_rdata[ENTRY_W-1];
  assign e_key   = ram_rdata[KEY_BITS+VALUE_BITS+STAMP_BITS-1 -: KEY_BITS];
  assign e_value = ram_rdata[VALUE_BITS+STAMP_BITS-1 -: VALUE_BITS];
  assign e_stamp = ram_rdata[STAMP_BITS-1:0];

  // Fit the incoming fields to the stored widths
  assign key_ext = {32'd0, req_i.cmd.key};
  assign age_ext = {{32{req_i.cmd.age[31]}}, req_i.cmd.age};
  assign rv_ext  = 64'(rd_val_q);

  assign stat_o.ready    = (state_q == ST_IDLE);
  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign empty_o         = !res_valid_q;
  assign result_o        = result_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    op_d         = op_q;
    key_d        = key_q;
    value_d      = value_q;
    stamp_d      = stamp_q;
    hit_found_d  = hit_found_q;
    hit_idx_d    = hit_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    rd_val_d     = rd_val_q;
    removed_d    = removed_q;
    result_d     = result_q;
    res_valid_d  = res_valid_q && !pop_i;
    ram_we       = 1'b0;
    ram_waddr    = pend_idx_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;

    case (state_q)
      // After reset, invalidate every entry in turn, then go idle
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[IDX_W-1:0];
        if (cnt_q[IDX_W-1:0] == LAST_IDX) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + (IDX_W + 1)'(1);
        end
      end

      // Take the next command and reset the sweep accumulators
      ST_IDLE: begin
        if (req_i.valid) begin
          op_d         = req_i.cmd.op;
          key_d        = key_ext[KEY_BITS-1:0];
          value_d      = 64'(req_i.cmd.value) >> 0 == 64'd0 ? '0 :
                         VALUE_BITS'(req_i.cmd.value);
          stamp_d      = age_ext[STAMP_BITS-1:0];
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
          rd_val_d     = '0;
          removed_d    = '0;
          cnt_d        = '0;
          pend_d       = 1'b0;
          state_d      = (req_i.cmd.op == OP_NONE) ? ST_DONE : ST_SWEEP;
        end
      end

      // Read one entry a cycle, inspect it in the cycle after its read
      ST_SWEEP: begin
        if (cnt_q < DEPTH_CNT) begin
          ram_re     = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = cnt_q[IDX_W-1:0];
          cnt_d      = cnt_q + (IDX_W + 1)'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          case (op_q)
            OP_INSERT: begin
              if (e_valid) begin
                if (!hit_found_q && (e_key == key_q)) begin
                  hit_found_d = 1'b1;
                  hit_idx_d   = pend_idx_q;
                end
              end else if (!free_found_q) begin
                free_found_d = 1'b1;
                free_idx_d   = pend_idx_q;
              end
            end
            OP_LOOKUP: begin
              if (e_valid && !hit_found_q && (e_key == key_q)) begin
                hit_found_d = 1'b1;
                rd_val_d    = e_value;
              end
            end
            OP_FLUSH: begin
              // Drop a stale entry by clearing its valid bit
              if (e_valid && ($signed(e_stamp) < $signed(stamp_q))) begin
                ram_we    = 1'b1;
                ram_waddr = pend_idx_q;
                ram_wdata = {1'b0, e_key, e_value, e_stamp};
                removed_d = removed_q + 5'd1;
              end
            end
            default: ;
          endcase
          if (pend_idx_q == LAST_IDX) begin
            state_d = ST_DONE;
          end
        end
      end

      // Commit an insert and post the result once the output register frees up
      ST_DONE: begin
        if (!res_valid_q || pop_i) begin
          res_valid_d            = 1'b1;
          state_d                = ST_IDLE;
          result_d.status        = STAT_MISS;
          result_d.read_value    = '0;
          result_d.removed_count = '0;
          case (op_q)
            OP_INSERT: begin
              ram_wdata = {1'b1, key_q, value_q, stamp_q};
              if (hit_found_q) begin
                ram_we          = 1'b1;
                ram_waddr       = hit_idx_q;
                result_d.status = STAT_REPLACED;
              end else if (free_found_q) begin
                ram_we          = 1'b1;
                ram_waddr       = free_idx_q;
                result_d.status = STAT_NEW;
              end else begin
                result_d.status = STAT_FULL;
              end
            end
            OP_LOOKUP: begin
              if (hit_found_q) begin
                result_d.status     = STAT_HIT;
                result_d.read_value = rv_ext[31:0];
              end
            end
            OP_FLUSH: begin
              result_d.status        = STAT_FLUSHED;
              result_d.removed_count = removed_q;
            end
            default: ;
          endcase
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      op_q         <= OP_NONE;
      key_q        <= '0;
      value_q      <= '0;
      stamp_q      <= '0;
      hit_found_q  <= 1'b0;
      hit_idx_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      rd_val_q     <= '0;
      removed_q    <= '0;
      result_q     <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      pend_q       <= pend_d;
      pend_idx_q   <= pend_idx_d;
      op_q         <= op_d;
      key_q        <= key_d;
      value_q      <= value_d;
      stamp_q      <= stamp_d;
      hit_found_q  <= hit_found_d;
      hit_idx_q    <= hit_idx_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      rd_val_q     <= rd_val_d;
      removed_q    <= removed_d;
      result_q     <= result_d;
      res_valid_q  <= res_valid_d;
    end
  end

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != cnt_q[IDX_W-1:0])
    else $error("table write and read hit the same entry");

  a_pend_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == ST_SWEEP)
    else $error("read data pending outside the sweep");

  a_done_posts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && !res_valid_q |=> res_valid_q && (state_q == ST_IDLE))
    else $error("finished command did not post a result");

endmodule

// ===== hw/rtl/expiring_key_value_table.sv =====
// Channel   Ports                       Handshake
// -------   -------------------------   ----------------------------------------
// input     item_i (in_word_t)          taken when push && !full
// result    result_o (out_word_t)       taken when pop && !empty
//
// Every insert, lookup or flush command sweeps the table one entry per cycle
// through the read port of the entry memory; an unused code skips the sweep.
// After reset the back end invalidates the table, one entry a cycle; full
// stays high until that pass ends.
// A two-word command queue lets new words in while a sweep runs or a result
// waits; the back end stalls only when the result register is still occupied.
module expiring_key_value_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32,
  parameter int STAMP_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ekvt_pkg::in_word_t  item_i,
  output logic                empty,
  input  logic                pop,
  output ekvt_pkg::out_word_t result_o
);
  import ekvt_pkg::*;

  cmd_req_t   req;
  back_stat_t stat;

  ekvt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item_i),
    .full_o (full),
    .req_o  (req),
    .stat_i (stat)
  );

  ekvt_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS),
    .STAMP_BITS  (STAMP_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .stat_o   (stat),
    .pop_i    (pop),
    .empty_o  (empty),
    .result_o (result_o)
  );

endmodule
